// File: hdl/servo_packet_framer_core_assert.svh
// ----------------------------------------------------------------------------
// servo_packet_framer_core_assert
// assertion macros used by the servo packet framer core
// ----------------------------------------------------------------------------
`ifndef SERVO_PACKET_FRAMER_CORE_ASSERT_SVH
`define SERVO_PACKET_FRAMER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while reset is held
`define SPF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// next-cycle implication, disabled while reset is held
`define SPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`else

`define SPF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// types, codes and packet tables of the servo packet framer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spf_pkg;

    // input item kinds
    typedef enum logic [2:0] {
        OP_GOAL_SINGLE = 3'd0,
        OP_READ_POS    = 3'd1,
        OP_GOAL_DUAL   = 3'd2,
        OP_OFF_DUAL    = 3'd3,
        OP_RX_BYTE     = 3'd4
    } t_opcode;

    // result kinds
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // reply slot codes
    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_NONE   = 2'd2;

    // configuration register indexes
    localparam logic CFG_FIRST_ID  = 1'b0;
    localparam logic CFG_SECOND_ID = 1'b1;

    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] CSUM_MASK  = 8'hFF;
    localparam int         HDR_LEN    = 3;

    // reply layout
    localparam int REPLY_BYTES = 9;
    localparam logic [3:0] RX_ID_IDX   = 4'(HDR_LEN);
    localparam logic [3:0] RX_LOW_IDX  = 4'(REPLY_BYTES - 3);
    localparam logic [3:0] RX_HIGH_IDX = 4'(REPLY_BYTES - 2);
    localparam logic [3:0] RX_LAST_IDX = 4'(REPLY_BYTES - 1);

    // one queued job: a command packet or a finished position report
    typedef struct packed {
        logic        is_report;
        t_opcode     op;
        logic [7:0]  id;        // target id, or reply id for a report
        logic [15:0] t1;        // first goal, or reply position for a report
        logic [15:0] t2;
        logic        ok;
        logic [1:0]  slot;
    } t_job;

    // packet length minus one, header and checksum included
    function automatic logic [3:0] pkt_last_idx(input t_opcode op);
        logic [3:0] r;
        case (op)
            OP_GOAL_SINGLE: r = 4'd9;
            OP_READ_POS:    r = 4'd8;
            OP_GOAL_DUAL:   r = 4'd14;
            OP_OFF_DUAL:    r = 4'd12;
            default:        r = 4'd0;
        endcase
        return r;
    endfunction

    // body byte k of a command packet
    function automatic logic [7:0] body_byte(
        input t_opcode    op,
        input logic [3:0] k,
        input logic [7:0] id,
        input logic [15:0] t1,
        input logic [15:0] t2,
        input logic [7:0] first_id,
        input logic [7:0] second_id
    );
        logic [7:0] r;
        r = 8'h00;
        case (op)
            OP_GOAL_SINGLE: begin
                case (k)
                    4'd0:    r = id;
                    4'd1:    r = 8'h05;
                    4'd2:    r = 8'hF3;
                    4'd3:    r = 8'h86;
                    4'd4:    r = t1[7:0];
                    4'd5:    r = t1[15:8];
                    default: r = 8'h00;
                endcase
            end
            OP_READ_POS: begin
                case (k)
                    4'd0:    r = id;
                    4'd1:    r = 8'h04;
                    4'd2:    r = 8'hF2;
                    4'd3:    r = 8'h8C;
                    4'd4:    r = 8'h02;
                    default: r = 8'h00;
                endcase
            end
            OP_GOAL_DUAL: begin
                case (k)
                    4'd0:    r = 8'hFE;
                    4'd1:    r = 8'h0A;
                    4'd2:    r = 8'h73;
                    4'd3:    r = 8'h86;
                    4'd4:    r = 8'h02;
                    4'd5:    r = first_id;
                    4'd6:    r = t1[7:0];
                    4'd7:    r = t1[15:8];
                    4'd8:    r = second_id;
                    4'd9:    r = t2[7:0];
                    4'd10:   r = t2[15:8];
                    default: r = 8'h00;
                endcase
            end
            OP_OFF_DUAL: begin
                case (k)
                    4'd0:    r = 8'hFE;
                    4'd1:    r = 8'h08;
                    4'd2:    r = 8'h73;
                    4'd3:    r = 8'h80;
                    4'd4:    r = 8'h01;
                    4'd5:    r = first_id;
                    4'd7:    r = second_id;
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/spf_front.sv
// ----------------------------------------------------------------------------
// spf_front
// accepts input items, tracks the reply receiver and queues jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spf_front
    import spf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_servo_id,
    input  logic [15:0] i_target_first,
    input  logic [15:0] i_target_second,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_first_id,
    input  logic [7:0]  i_second_id,
    output logic        o_push,
    output t_job        o_job
);

    logic [3:0] r_rx_count, n_rx_count;
    logic       r_rx_armed, n_rx_armed;
    logic [7:0] r_rx_sum,   n_rx_sum;
    logic [7:0] r_rx_id,    n_rx_id;
    logic [7:0] r_rx_low,   n_rx_low;
    logic [7:0] r_rx_high,  n_rx_high;

    t_opcode w_op;
    assign w_op = t_opcode'(i_opcode);

    // classify the item and update the receiver
    always_comb begin
        n_rx_count = r_rx_count;
        n_rx_armed = r_rx_armed;
        n_rx_sum   = r_rx_sum;
        n_rx_id    = r_rx_id;
        n_rx_low   = r_rx_low;
        n_rx_high  = r_rx_high;
        o_push     = 1'b0;
        o_job.is_report = 1'b0;
        o_job.op        = w_op;
        o_job.id        = i_servo_id;
        o_job.t1        = i_target_first;
        o_job.t2        = i_target_second;
        o_job.ok        = 1'b0;
        o_job.slot      = SLOT_FIRST;
        if (i_accept) begin
            case (w_op)
                OP_GOAL_SINGLE, OP_GOAL_DUAL, OP_OFF_DUAL: begin
                    o_push = 1'b1;
                end
                OP_READ_POS: begin
                    o_push     = 1'b1;
                    n_rx_armed = 1'b1;
                    n_rx_count = 4'd0;
                    n_rx_sum   = 8'h00;
                end
                OP_RX_BYTE: begin
                    if (r_rx_armed) begin
                        if (r_rx_count >= RX_LAST_IDX) begin
                            // final reply byte: build the report
                            o_push          = 1'b1;
                            o_job.is_report = 1'b1;
                            o_job.id        = r_rx_id;
                            o_job.t1        = {r_rx_high, r_rx_low};
                            o_job.ok        = ((r_rx_sum ^ CSUM_MASK) == i_rx_byte);
                            if (r_rx_id == i_first_id) begin
                                o_job.slot = SLOT_FIRST;
                            end else if (r_rx_id == i_second_id) begin
                                o_job.slot = SLOT_SECOND;
                            end else begin
                                o_job.slot = SLOT_NONE;
                            end
                            n_rx_armed = 1'b0;
                            n_rx_count = 4'd0;
                            n_rx_sum   = 8'h00;
                        end else begin
                            if (r_rx_count >= RX_ID_IDX) begin
                                n_rx_sum = r_rx_sum + i_rx_byte;
                            end
                            if (r_rx_count == RX_ID_IDX) begin
                                n_rx_id = i_rx_byte;
                            end
                            if (r_rx_count == RX_LOW_IDX) begin
                                n_rx_low = i_rx_byte;
                            end
                            if (r_rx_count == RX_HIGH_IDX) begin
                                n_rx_high = i_rx_byte;
                            end
                            n_rx_count = r_rx_count + 4'd1;
                        end
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    // receiver state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count <= 4'd0;
            r_rx_armed <= 1'b0;
            r_rx_sum   <= 8'h00;
            r_rx_id    <= 8'h00;
            r_rx_low   <= 8'h00;
            r_rx_high  <= 8'h00;
        end else begin
            r_rx_count <= n_rx_count;
            r_rx_armed <= n_rx_armed;
            r_rx_sum   <= n_rx_sum;
            r_rx_id    <= n_rx_id;
            r_rx_low   <= n_rx_low;
            r_rx_high  <= n_rx_high;
        end
    end

endmodule

// File: hdl/spf_queue.sv
// ----------------------------------------------------------------------------
// spf_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spf_queue
    import spf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  t_job                         i_job,
    input  logic                         i_pop,
    output t_job                         o_head,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_count = r_count;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: hdl/spf_back.sv
// ----------------------------------------------------------------------------
// spf_back
// serializes queued jobs to packet bytes and reports, one per unstalled cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spf_back
    import spf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  logic        i_empty,
    input  logic [7:0]  i_first_id,
    input  logic [7:0]  i_second_id,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [39:0] o_tdata,
    output logic        o_tlast,
    output logic        o_tuser
);

    logic [3:0]  r_idx, n_idx;
    logic [7:0]  r_sum, n_sum;
    logic        r_valid, n_valid;
    logic [39:0] r_data, n_data;
    logic        r_last, n_last;
    logic        r_kind, n_kind;

    logic       w_adv;
    logic [3:0] w_last_idx;
    logic [7:0] w_byte;
    logic       w_end;

    assign w_adv      = !i_empty && (!r_valid || i_tready);
    assign w_last_idx = pkt_last_idx(i_head.op);
    assign w_end      = i_head.is_report || (r_idx == w_last_idx);

    // current packet byte
    always_comb begin
        if (r_idx < 4'(HDR_LEN)) begin
            w_byte = HDR_BYTE;
        end else if (r_idx == w_last_idx) begin
            w_byte = r_sum ^ CSUM_MASK;
        end else begin
            w_byte = body_byte(i_head.op, r_idx - 4'(HDR_LEN), i_head.id, i_head.t1,
                               i_head.t2, i_first_id, i_second_id);
        end
    end

    // byte sequencer and output register
    always_comb begin
        n_idx   = r_idx;
        n_sum   = r_sum;
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        n_kind  = r_kind;
        o_pop   = 1'b0;
        if (w_adv) begin
            n_valid = 1'b1;
            if (i_head.is_report) begin
                n_kind = KIND_REPORT;
                n_last = 1'b0;
                n_data = {5'd0, i_head.t1, i_head.slot, i_head.id, i_head.ok, 8'h00};
            end else begin
                n_kind = KIND_TX;
                n_last = (r_idx == w_last_idx);
                n_data = {32'd0, w_byte};
                n_sum  = (r_idx < 4'(HDR_LEN)) ? 8'h00 : r_sum + w_byte;
            end
            if (w_end) begin
                o_pop = 1'b1;
                n_idx = 4'd0;
            end else begin
                n_idx = r_idx + 4'd1;
            end
        end else if (i_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_data <= n_data;
        r_last <= n_last;
        r_kind <= n_kind;
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;
    assign o_tuser  = r_kind;

endmodule

// File: hdl/servo_packet_framer_core.sv
// ----------------------------------------------------------------------------
// servo_packet_framer_core
// servo bus command packet builder and position reply parser
// ----------------------------------------------------------------------------
// Items are accepted one per cycle while the job queue has room. A command
// produces its packet (FF FF FF, body, inverted byte-sum checksum) one byte
// per cycle unless stalled: 10, 9, 15 or 13 bytes for single goal, read
// position, dual goal and dual motor off. The ninth received reply byte after
// a read position produces one position report. The output byte sequencer,
// at one result per cycle unless stalled, sets the sustained rate; the queue
// of QUEUE_DEPTH jobs lets input keep flowing while a packet drains.
`timescale 1ns / 1ps
`include "servo_packet_framer_core_assert.svh"

module servo_packet_framer_core
    import spf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] servo_id, [23:8] target_first, [39:24] target_second, [47:40] rx_byte
    input  logic [47:0] s_axis_tdata,
    // [2:0] opcode
    input  logic [2:0]  s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] tx_byte, [8] reply_ok, [16:9] reply_servo_id, [18:17] reply_slot,
    // [34:19] reply_position, [39:35] zero
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // [0] result_kind
    output logic        m_axis_tuser
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [7:0] r_first_id;
    logic [7:0] r_second_id;

    logic             w_accept;
    logic             w_push;
    t_job             w_job;
    logic             w_pop;
    t_job             w_head;
    logic             w_empty;
    logic             w_full;
    logic [CNT_W-1:0] w_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_id  <= 8'd1;
            r_second_id <= 8'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_ID:  r_first_id  <= i_cfg_wdata;
                CFG_SECOND_ID: r_second_id <= i_cfg_wdata;
                default:       r_first_id  <= r_first_id;
            endcase
        end
    end

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // front: classify items and track the reply
    spf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_opcode        (s_axis_tuser),
        .i_servo_id      (s_axis_tdata[7:0]),
        .i_target_first  (s_axis_tdata[23:8]),
        .i_target_second (s_axis_tdata[39:24]),
        .i_rx_byte       (s_axis_tdata[47:40]),
        .i_first_id      (r_first_id),
        .i_second_id     (r_second_id),
        .o_push          (w_push),
        .o_job           (w_job)
    );

    // job queue
    spf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_count (w_count)
    );

    // back: byte sequencer and output register
    spf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .i_first_id  (r_first_id),
        .i_second_id (r_second_id),
        .o_pop       (w_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast),
        .o_tuser     (m_axis_tuser)
    );

    // checks
    `SPF_ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1, w_count <= CNT_W'(QUEUE_DEPTH))
    `SPF_ASSERT_IMPL(a_ready_room, i_clk, i_rst_n, 1'b1, s_axis_tready == (w_count != CNT_W'(QUEUE_DEPTH)))
    `SPF_ASSERT_IMPL(a_last_tx_only, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser == KIND_TX)
    `SPF_ASSERT_NEXT(a_pop_shows, i_clk, i_rst_n, w_pop, m_axis_tvalid)

endmodule
